>>> sv/htc_pkg.sv
// ----------------------------------------------------------------------------
// htc_pkg: shared types and constants
// Request/response structs, mode codes and counter helpers for the cascade.
// ----------------------------------------------------------------------------
package htc_pkg;

  localparam int NODE_W = 10;
  localparam int EDGE_W = 10;
  localparam int CNT_W  = 11;
  localparam int PCT_W  = 7;
  localparam int PROD_W = 18;

  localparam int NODES_DEF      = 1024;
  localparam int EDGES_DEF      = 1024;
  localparam int INCIDENCES_DEF = 4096;

  localparam logic [CNT_W-1:0] CNT_SAT   = 11'd2047;
  localparam logic [PCT_W-1:0] PCT_RESET = 7'd80;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_SEED  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [NODE_W-1:0] node_id;
    logic [EDGE_W-1:0] edge_id;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0] active_node_count;
    logic [CNT_W-1:0] active_edge_count;
    logic             node_is_active;
    logic             status;
  } rsp_t;

  // saturating increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_SAT) ? v : v + 1'b1;
  endfunction

  // c * 100 by shift-add
  function automatic logic [PROD_W-1:0] times100(input logic [CNT_W-1:0] c);
    logic [PROD_W-1:0] x;
    x = PROD_W'(c);
    return (x << 6) + (x << 5) + (x << 2);
  endfunction

endpackage

>>> sv/htc_ram.sv
// ----------------------------------------------------------------------------
// htc_ram: generic single-port-write RAM
// One write and one read port, registered read data.
// ----------------------------------------------------------------------------
module htc_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/hypergraph_threshold_cascade.sv
// ----------------------------------------------------------------------------
// hypergraph_threshold_cascade: threshold cascade over a stored hypergraph
// Load appends one incidence unless the store is full; query only reports; clear wipes activation.
// Seed marks the node active and queues it; each dequeued node has its incidences
// scanned, and for each one in an inactive edge its unmarked entries there are
// counted; an edge that reaches its threshold fires and wakes its members.
// All of it is run by one sequencer scanning the incidence RAM entry by entry; a
// stalled response holds the sequencer until the response can be loaded.
// One request in flight at a time; a response may wait while the next is taken.
// Reset (sync, active high) runs a clearing pass over all node, edge and
// incidence entries, not ready meanwhile; config writes are taken throughout.
// ----------------------------------------------------------------------------
module hypergraph_threshold_cascade #(
  parameter int NODES      = htc_pkg::NODES_DEF,
  parameter int EDGES      = htc_pkg::EDGES_DEF,
  parameter int INCIDENCES = htc_pkg::INCIDENCES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [htc_pkg::PCT_W-1:0] cfg_wdata,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  htc_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output htc_pkg::rsp_t             rsp
);

  localparam int NA   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int EA   = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int IA   = (INCIDENCES > 1) ? $clog2(INCIDENCES) : 1;
  localparam int FW   = $clog2(INCIDENCES + 1);
  localparam int QW   = $clog2(NODES + 1);
  localparam int DNE  = (NODES > EDGES) ? NODES : EDGES;
  localparam int DMAX = (DNE > INCIDENCES) ? DNE : INCIDENCES;
  localparam int CW   = (DMAX > 1) ? $clog2(DMAX) : 1;
  localparam int IW   = htc_pkg::NODE_W + htc_pkg::EDGE_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_LOAD, S_SEED, S_POP, S_POPW, S_IRD, S_IUSE,
    S_ECHK, S_JRD, S_JUSE, S_KRD, S_KUSE, S_WAKE, S_FLAG, S_FLAGW
  } state_t;

  state_t                      state;
  htc_pkg::req_t               cur;
  logic [htc_pkg::PCT_W-1:0]   pct;
  logic [FW-1:0]               fill;
  logic [htc_pkg::CNT_W-1:0]   nodes_on, edges_on;
  logic [QW-1:0]               q_head, q_tail;
  logic [htc_pkg::NODE_W-1:0]  v, w;
  logic [htc_pkg::EDGE_W-1:0]  e;
  logic [htc_pkg::CNT_W-1:0]   cnt;
  logic [htc_pkg::PROD_W-1:0]  prod;
  logic [FW-1:0]               i, j;    // outer scan, inner/fire scan
  logic [CW-1:0]               clr;
  logic                        clr_all; // reset pass also clears edge sizes
  logic                        status;

  // RAM ports
  logic                        na_we, na_wd, na_rd;
  logic [NA-1:0]               na_wa, na_ra;
  logic                        ea_we, ea_wd, ea_rd;
  logic                        ec_we, es_we;
  logic [EA-1:0]               ea_wa, ec_wa, es_wa, e_ra;
  logic [htc_pkg::CNT_W-1:0]   ec_wd, ec_rd, es_wd, es_rd;
  logic                        inc_we;
  logic [IA-1:0]               inc_wa, inc_ra;
  logic [IW-1:0]               inc_wd, inc_rd;
  logic                        mk_we, mk_wd, mk_rd;
  logic [IA-1:0]               mk_wa;
  logic                        q_we;
  logic [NA-1:0]               q_wa, q_ra;
  logic [htc_pkg::NODE_W-1:0]  q_wd, q_rd;

  logic [htc_pkg::NODE_W-1:0]  inc_node;
  logic [htc_pkg::EDGE_W-1:0]  inc_edge;
  logic [htc_pkg::CNT_W-1:0]   cnt_next;
  logic                        j_hit, k_hit, fire;
  logic                        req_node_ok, req_edge_ok, cur_node_ok;

  assign inc_node    = inc_rd[IW-1:htc_pkg::EDGE_W];
  assign inc_edge    = inc_rd[htc_pkg::EDGE_W-1:0];
  assign cnt_next    = htc_pkg::sat_inc(cnt);
  assign j_hit       = (inc_node == v) && (inc_edge == e) && !mk_rd;
  assign k_hit       = (inc_edge == e) && !mk_rd;
  // count >= ceil(size*pct/100)  <=>  count*100 >= size*pct
  assign fire        = htc_pkg::times100(cnt_next) >= prod;
  assign req_node_ok = int'(req.node_id) < NODES;
  assign req_edge_ok = int'(req.edge_id) < EDGES;
  assign cur_node_ok = int'(cur.node_id) < NODES;
  assign req_ready   = (state == S_IDLE);

  // read addresses
  always_comb begin
    if (state == S_IDLE) begin
      na_ra = NA'(req.node_id);
    end else if (state == S_KUSE) begin
      na_ra = NA'(inc_node);
    end else begin
      na_ra = NA'(cur.node_id);
    end
    if (state == S_IDLE) begin
      e_ra = EA'(req.edge_id);
    end else if (state == S_IUSE) begin
      e_ra = EA'(inc_edge);
    end else begin
      e_ra = EA'(cur.edge_id);
    end
    inc_ra = (state == S_IRD) ? IA'(i) : IA'(j);
    q_ra   = NA'(q_head);
  end

  // write ports
  always_comb begin
    na_we  = 1'b0; na_wa = NA'(cur.node_id); na_wd = 1'b1;
    ea_we  = 1'b0; ea_wa = EA'(e);           ea_wd = 1'b1;
    ec_we  = 1'b0; ec_wa = EA'(e);           ec_wd = cnt_next;
    es_we  = 1'b0; es_wa = EA'(cur.edge_id); es_wd = htc_pkg::sat_inc(es_rd);
    inc_we = 1'b0; inc_wa = IA'(fill);       inc_wd = {cur.node_id, cur.edge_id};
    mk_we  = 1'b0; mk_wa = IA'(j);           mk_wd = 1'b1;
    q_we   = 1'b0; q_wa = NA'(q_tail);       q_wd = w;
    unique case (state)
      S_CLR: begin
        na_we = int'(clr) < NODES;      na_wa = NA'(clr); na_wd = 1'b0;
        ea_we = int'(clr) < EDGES;      ea_wa = EA'(clr); ea_wd = 1'b0;
        ec_we = int'(clr) < EDGES;      ec_wa = EA'(clr); ec_wd = '0;
        es_we = clr_all && (int'(clr) < EDGES);
        es_wa = EA'(clr);               es_wd = '0;
        mk_we = int'(clr) < INCIDENCES; mk_wa = IA'(clr); mk_wd = 1'b0;
      end
      S_LOAD: begin
        es_we  = 1'b1;
        inc_we = 1'b1;
        mk_we  = 1'b1; mk_wa = IA'(fill); mk_wd = 1'b0;
      end
      S_SEED: begin
        na_we = !na_rd;
        q_we  = !na_rd; q_wa = '0; q_wd = cur.node_id;
      end
      S_JUSE: begin
        mk_we = j_hit;
        ec_we = j_hit;
        ea_we = j_hit && fire;
      end
      S_KUSE: begin
        mk_we = k_hit;
      end
      S_WAKE: begin
        na_we = !na_rd; na_wa = NA'(w);
        q_we  = !na_rd && (int'(q_tail) < NODES);
      end
      default: begin
      end
    endcase
  end

  htc_ram #(.W(1), .D(NODES)) u_node_act (
    .clk, .we(na_we), .waddr(na_wa), .wdata(na_wd), .raddr(na_ra), .rdata(na_rd));
  htc_ram #(.W(1), .D(EDGES)) u_edge_act (
    .clk, .we(ea_we), .waddr(ea_wa), .wdata(ea_wd), .raddr(e_ra), .rdata(ea_rd));
  htc_ram #(.W(htc_pkg::CNT_W), .D(EDGES)) u_edge_cnt (
    .clk, .we(ec_we), .waddr(ec_wa), .wdata(ec_wd), .raddr(e_ra), .rdata(ec_rd));
  htc_ram #(.W(htc_pkg::CNT_W), .D(EDGES)) u_edge_size (
    .clk, .we(es_we), .waddr(es_wa), .wdata(es_wd), .raddr(e_ra), .rdata(es_rd));
  htc_ram #(.W(IW), .D(INCIDENCES)) u_inc (
    .clk, .we(inc_we), .waddr(inc_wa), .wdata(inc_wd), .raddr(inc_ra), .rdata(inc_rd));
  htc_ram #(.W(1), .D(INCIDENCES)) u_marked (
    .clk, .we(mk_we), .waddr(mk_wa), .wdata(mk_wd), .raddr(inc_ra), .rdata(mk_rd));
  htc_ram #(.W(htc_pkg::NODE_W), .D(NODES)) u_queue (
    .clk, .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      clr_all   <= 1'b1;
      pct       <= htc_pkg::PCT_RESET;
      fill      <= '0;
      nodes_on  <= '0;
      edges_on  <= '0;
      q_head    <= '0;
      q_tail    <= '0;
      status    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        pct <= cfg_wdata;
      end
      // a response loaded in S_FLAGW takes precedence over the drop
      if (rsp_valid && rsp_ready && (state != S_FLAGW)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur    <= req;
            status <= (req.mode == htc_pkg::MODE_LOAD) && (int'(fill) >= INCIDENCES);
            unique case (req.mode)
              htc_pkg::MODE_LOAD: begin
                if (int'(fill) >= INCIDENCES) begin
                  state <= S_FLAG;
                end else if (req_node_ok && req_edge_ok) begin
                  state <= S_LOAD;
                end else begin
                  state <= S_FLAG;
                end
              end
              htc_pkg::MODE_SEED:  state <= req_node_ok ? S_SEED : S_FLAG;
              htc_pkg::MODE_QUERY: state <= S_FLAG;
              htc_pkg::MODE_CLEAR: begin
                clr     <= '0;
                clr_all <= 1'b0;
                state   <= S_CLR;
              end
              default: state <= S_FLAG;
            endcase
          end
        end
        S_CLR: begin
          if (clr == CW'(DMAX - 1)) begin
            nodes_on <= '0;
            edges_on <= '0;
            state    <= clr_all ? S_IDLE : S_FLAG;
          end else begin
            clr <= clr + 1'b1;
          end
        end
        S_LOAD: begin
          fill  <= fill + 1'b1;
          state <= S_FLAG;
        end
        S_SEED: begin
          if (na_rd) begin
            state <= S_FLAG;
          end else begin
            nodes_on <= htc_pkg::sat_inc(nodes_on);
            q_head   <= '0;
            q_tail   <= QW'(1);
            state    <= S_POP;
          end
        end
        S_POP: begin
          if (q_head == q_tail) begin
            state <= S_FLAG;
          end else begin
            q_head <= q_head + 1'b1;
            state  <= S_POPW;
          end
        end
        S_POPW: begin
          v     <= q_rd;
          i     <= '0;
          state <= S_IRD;
        end
        S_IRD: begin
          state <= (i == fill) ? S_POP : S_IUSE;
        end
        S_IUSE: begin
          if (inc_node != v) begin
            i     <= i + 1'b1;
            state <= S_IRD;
          end else begin
            e     <= inc_edge;
            state <= S_ECHK;
          end
        end
        S_ECHK: begin
          if (ea_rd) begin
            i     <= i + 1'b1;
            state <= S_IRD;
          end else begin
            cnt   <= ec_rd;
            prod  <= htc_pkg::PROD_W'(es_rd) * htc_pkg::PROD_W'(pct);
            j     <= '0;
            state <= S_JRD;
          end
        end
        S_JRD: begin
          if (j == fill) begin
            i     <= i + 1'b1;
            state <= S_IRD;
          end else begin
            state <= S_JUSE;
          end
        end
        S_JUSE: begin
          if (j_hit) begin
            cnt <= cnt_next;
          end
          if (j_hit && fire) begin
            edges_on <= htc_pkg::sat_inc(edges_on);
            j        <= '0;
            state    <= S_KRD;
          end else begin
            j     <= j + 1'b1;
            state <= S_JRD;
          end
        end
        S_KRD: begin
          if (j == fill) begin
            i     <= i + 1'b1;
            state <= S_IRD;
          end else begin
            state <= S_KUSE;
          end
        end
        S_KUSE: begin
          if (k_hit) begin
            w     <= inc_node;
            state <= S_WAKE;
          end else begin
            j     <= j + 1'b1;
            state <= S_KRD;
          end
        end
        S_WAKE: begin
          if (!na_rd) begin
            nodes_on <= htc_pkg::sat_inc(nodes_on);
            if (int'(q_tail) < NODES) begin
              q_tail <= q_tail + 1'b1;
            end
          end
          j     <= j + 1'b1;
          state <= S_KRD;
        end
        S_FLAG: begin
          state <= S_FLAGW;
        end
        S_FLAGW: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid                 <= 1'b1;
            rsp.active_node_count     <= nodes_on;
            rsp.active_edge_count     <= edges_on;
            rsp.node_is_active        <= cur_node_ok && na_rd;
            rsp.status                <= status;
            state                     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(fill) <= INCIDENCES)
    else $error("incidence fill past store depth");

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    q_head <= q_tail)
    else $error("queue head passed tail");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    int'(q_tail) <= NODES)
    else $error("queue tail past node count");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |-> int'(fill) == INCIDENCES)
    else $error("drop flagged while store not full");

endmodule

>>> dv/hypergraph_threshold_cascade_tb.sv
// ----------------------------------------------------------------------------
// hypergraph_threshold_cascade_tb: self-checking bench for the cascade block
// Drives load, seed, query and clear requests under several threshold
// settings, with random idling on both sides. A scoreboard predicts every
// response and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hypergraph_threshold_cascade_tb;

  localparam int N_NODES = 1024;
  localparam int N_EDGES = 1024;
  localparam int N_INC   = 4096;
  localparam int RING    = 16;

  // Shadow of the hypergraph and its activation state. Each accepted request
  // is folded in at once, and the response it should give is held in a ring.
  class cascade_scoreboard;
    logic [htc_pkg::PCT_W-1:0]  pct;
    bit                         node_on [N_NODES];
    bit                         edge_on [N_EDGES];
    logic [htc_pkg::CNT_W-1:0]  member_cnt [N_EDGES];
    logic [htc_pkg::CNT_W-1:0]  edge_len [N_EDGES];
    logic [htc_pkg::NODE_W-1:0] inc_node [N_INC];
    logic [htc_pkg::EDGE_W-1:0] inc_edge [N_INC];
    bit                         inc_mark [N_INC];
    int                         fill;
    logic [htc_pkg::CNT_W-1:0]  nodes_lit, edges_lit;
    int                         pend [N_NODES];
    int                         pend_head, pend_tail;
    htc_pkg::rsp_t              exp_ring [RING];
    int                         exp_wr, exp_rd;
    int                         errors;

    function new();
      pct = htc_pkg::PCT_RESET;
      fill = 0;
      errors = 0;
      exp_wr = 0;
      exp_rd = 0;
      pend_head = 0;
      pend_tail = 0;
      foreach (edge_len[e]) edge_len[e] = '0;
      reset_activation();
    endfunction

    function int outstanding();
      return exp_wr - exp_rd;
    endfunction

    function void reset_activation();
      foreach (node_on[n]) node_on[n] = 1'b0;
      foreach (edge_on[e]) begin
        edge_on[e] = 1'b0;
        member_cnt[e] = '0;
      end
      foreach (inc_mark[i]) inc_mark[i] = 1'b0;
      nodes_lit = '0;
      edges_lit = '0;
    endfunction

    function logic [htc_pkg::CNT_W-1:0] bump(logic [htc_pkg::CNT_W-1:0] v);
      return (v == htc_pkg::CNT_SAT) ? v : v + 1'b1;
    endfunction

    function void wake(int v);
      if (node_on[v]) return;
      node_on[v] = 1'b1;
      nodes_lit = bump(nodes_lit);
      if (pend_tail < N_NODES) begin
        pend[pend_tail] = v;
        pend_tail++;
      end
    endfunction

    function void fire(int e);
      edge_on[e] = 1'b1;
      edges_lit = bump(edges_lit);
      for (int j = 0; j < fill; j++)
        if (inc_edge[j] == e && !inc_mark[j]) begin
          inc_mark[j] = 1'b1;
          wake(inc_node[j]);
        end
    endfunction

    // breadth-first spread from one seed node
    function void spread(int seed);
      int v, e, need;
      pend_head = 0;
      pend_tail = 0;
      wake(seed);
      while (pend_head < pend_tail) begin
        v = pend[pend_head];
        pend_head++;
        for (int i = 0; i < fill; i++) begin
          if (inc_node[i] != v) continue;
          e = inc_edge[i];
          if (edge_on[e]) continue;
          for (int j = 0; j < fill; j++)
            if (inc_edge[j] == e && inc_node[j] == v && !inc_mark[j]) begin
              inc_mark[j] = 1'b1;
              member_cnt[e] = bump(member_cnt[e]);
              need = (int'(edge_len[e]) * int'(pct) + 99) / 100;
              if (int'(member_cnt[e]) >= need) begin
                fire(e);
                break;
              end
            end
        end
      end
    endfunction

    function void note_request(htc_pkg::req_t r);
      htc_pkg::rsp_t x;
      x = '0;
      case (r.mode)
        htc_pkg::MODE_LOAD: begin
          if (fill >= N_INC) x.status = 1'b1;
          else begin
            inc_node[fill] = r.node_id;
            inc_edge[fill] = r.edge_id;
            inc_mark[fill] = 1'b0;
            fill++;
            edge_len[r.edge_id] = bump(edge_len[r.edge_id]);
          end
        end
        htc_pkg::MODE_SEED: if (!node_on[r.node_id]) spread(r.node_id);
        htc_pkg::MODE_CLEAR: reset_activation();
        default: ;
      endcase
      x.active_node_count = nodes_lit;
      x.active_edge_count = edges_lit;
      x.node_is_active = node_on[r.node_id];
      exp_ring[exp_wr % RING] = x;
      exp_wr++;
    endfunction

    function void check_response(htc_pkg::rsp_t a);
      htc_pkg::rsp_t x;
      if (outstanding() == 0) begin
        $display("%0t: response with nothing outstanding, got %h", $time, a);
        errors++;
        return;
      end
      x = exp_ring[exp_rd % RING];
      exp_rd++;
      if (a.active_node_count !== x.active_node_count) begin
        $display("%0t: active_node_count exp %0d got %0d", $time,
                 x.active_node_count, a.active_node_count);
        errors++;
      end
      if (a.active_edge_count !== x.active_edge_count) begin
        $display("%0t: active_edge_count exp %0d got %0d", $time,
                 x.active_edge_count, a.active_edge_count);
        errors++;
      end
      if (a.node_is_active !== x.node_is_active) begin
        $display("%0t: node_is_active exp %b got %b", $time,
                 x.node_is_active, a.node_is_active);
        errors++;
      end
      if (a.status !== x.status) begin
        $display("%0t: status exp %b got %b", $time, x.status, a.status);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [htc_pkg::PCT_W-1:0] cfg_wdata;
  logic                      req_valid;
  logic                      req_ready;
  htc_pkg::req_t             req;
  logic                      rsp_valid;
  logic                      rsp_ready;
  htc_pkg::rsp_t             rsp;

  cascade_scoreboard sb;
  bit steady;   // set for the closing stretch: no idling on either side

  hypergraph_threshold_cascade uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // responses are taken at the rising edge; the expectation was noted when
  // its request went in, always on an earlier edge
  always @(posedge clk)
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);

  // sink back-pressure: randomly chosen stretches of stalled and ready cycles
  initial begin
    int n;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!steady && $urandom_range(0, 3) == 0) begin
        rsp_ready = 1'b0;
        n = $urandom_range(1, 16);
        repeat (n - 1) @(negedge clk);
      end else begin
        rsp_ready = 1'b1;
        n = $urandom_range(1, 20);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // one request: optional idle burst, then hold valid until taken
  task automatic send_request(input logic [1:0] m, input int n, input int e);
    int gap;
    if (!steady && $urandom_range(0, 4) == 0) begin
      req_valid = 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    req_valid = 1'b1;
    req.mode = m;
    req.node_id = n[htc_pkg::NODE_W-1:0];
    req.edge_id = e[htc_pkg::EDGE_W-1:0];
    do @(posedge clk); while (!req_ready);
    sb.note_request(req);
    @(negedge clk);
  endtask

  task automatic drain();
    req_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // threshold changes only with the block idle
  task automatic set_threshold(input int p);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = p[htc_pkg::PCT_W-1:0];
    sb.pct = p[htc_pkg::PCT_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // random requests over a small node/edge pool so cascades actually spread;
  // now and then a full-range id
  task automatic random_requests(input int count);
    int pick, n, e;
    logic [1:0] m;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      m = htc_pkg::MODE_LOAD;
      else if (pick < 60) m = htc_pkg::MODE_SEED;
      else if (pick < 92) m = htc_pkg::MODE_QUERY;
      else                m = htc_pkg::MODE_CLEAR;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, N_NODES - 1)
                                      : $urandom_range(0, 15);
      e = ($urandom_range(0, 9) == 0) ? $urandom_range(0, N_EDGES - 1)
                                      : $urandom_range(0, 7);
      send_request(m, n, e);
    end
  endtask

  initial begin
    sb = new();
    steady = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_valid = 1'b0;
    req = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // directed: field extremes, all modes, seed of an active node,
    // seed of an isolated node, load after a cascade, clear then query
    send_request(htc_pkg::MODE_LOAD, 1023, 1023);
    send_request(htc_pkg::MODE_LOAD, 0, 1023);
    send_request(htc_pkg::MODE_LOAD, 0, 0);
    send_request(htc_pkg::MODE_LOAD, 'h2AA, 'h155);
    send_request(htc_pkg::MODE_LOAD, 'h155, 'h2AA);
    send_request(htc_pkg::MODE_LOAD, 'h155, 'h155);
    send_request(htc_pkg::MODE_LOAD, 5, 0);
    send_request(htc_pkg::MODE_QUERY, 1023, 0);
    send_request(htc_pkg::MODE_SEED, 1023, 0);
    send_request(htc_pkg::MODE_QUERY, 0, 0);
    send_request(htc_pkg::MODE_SEED, 1023, 0);
    send_request(htc_pkg::MODE_SEED, 700, 0);
    send_request(htc_pkg::MODE_SEED, 'h2AA, 0);
    send_request(htc_pkg::MODE_LOAD, 9, 1023);
    send_request(htc_pkg::MODE_QUERY, 9, 1023);
    send_request(htc_pkg::MODE_SEED, 5, 0);
    send_request(htc_pkg::MODE_QUERY, 'h155, 0);
    send_request(htc_pkg::MODE_CLEAR, 1023, 1023);
    send_request(htc_pkg::MODE_QUERY, 1023, 0);
    send_request(htc_pkg::MODE_SEED, 0, 0);
    send_request(htc_pkg::MODE_QUERY, 5, 0);

    // zero lights an edge on its first mark; above 100 no edge can light
    set_threshold(0);
    random_requests(45);
    set_threshold(127);
    random_requests(45);
    set_threshold(1);
    random_requests(45);
    set_threshold(100);
    random_requests(45);
    set_threshold(50);
    random_requests(45);
    set_threshold(33);
    steady = 1'b1;
    random_requests(40);

    send_request(htc_pkg::MODE_QUERY, 3, 0);
    send_request(htc_pkg::MODE_CLEAR, 0, 0);
    send_request(htc_pkg::MODE_QUERY, 3, 0);

    req_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #400_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
